### rtl/supercap_charge_and_speed_limit_defines.svh
// assertion macros shared by sccl_ctrl and sccl_dp
`ifndef SUPERCAP_CHARGE_AND_SPEED_LIMIT_DEFINES_SVH
`define SUPERCAP_CHARGE_AND_SPEED_LIMIT_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define SCCL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
// checked at every edge, reset included
`define SCCL_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define SCCL_ASSERT(lbl, prop, msg)
`define SCCL_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

### rtl/sccl_pkg.sv
package sccl_pkg;

  typedef struct packed {
    logic [15:0] cap_voltage;
    logic [15:0] motor_power;
    logic [7:0]  buffer_energy;
    logic        boost_request;
    logic        protect_req;
  } in_t;

  typedef struct packed {
    logic [1:0]  cap_mode;
    logic [14:0] power_ref_cw;
    logic [9:0]  charge_current;
    logic [13:0] wheel_speed_limit;
    logic        discharge_enable;
  } out_t;

  // controller to datapath
  typedef struct packed {
    logic start;
    logic load;
    logic step;
    logic publish;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic last_step;
    logic out_free;
  } status_t;

  localparam int CfgAddrW = 2;
  localparam int CfgDataW = 12;
  localparam logic [CfgAddrW-1:0] REG_PWR_CEIL      = 2'd0;
  localparam logic [CfgAddrW-1:0] REG_LIMIT_VOLTAGE = 2'd1;
  localparam logic [CfgAddrW-1:0] REG_BUF_FLOOR     = 2'd2;

  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_CHARGE = 2'd1;
  localparam logic [1:0] MODE_BOOST  = 2'd2;

  localparam logic [15:0] VOLT_LOW_CV     = 16'd1350;
  localparam logic [15:0] VOLT_HIGH_CV    = 16'd1500;
  localparam logic [16:0] POWER_MARGIN_CW = 17'd1000;
  localparam logic [7:0]  BUFFER_CAP_J    = 8'd60;
  localparam logic [9:0]  CURRENT_MAX_CA  = 10'd1000;
  localparam logic [13:0] BOOST_WHEEL     = 14'd8500;

  // dividend is ref * 100, below 2^22
  localparam int DivBits = 22;
  localparam int CntW    = $clog2(DivBits);

  function automatic logic [13:0] wheel_lookup(input logic [7:0] p);
    logic [13:0] w;
    case (p)
      8'd45:   w = 14'd4550;
      8'd50:   w = 14'd5500;
      8'd55:   w = 14'd5800;
      8'd60:   w = 14'd6200;
      8'd80:   w = 14'd6500;
      8'd100:  w = 14'd7600;
      8'd120:  w = 14'd7650;
      8'd255:  w = 14'd7650;
      default: w = 14'd5500;
    endcase
    return w;
  endfunction

endpackage

### rtl/sccl_ctrl.sv
`include "supercap_charge_and_speed_limit_defines.svh"

module sccl_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  sccl_pkg::status_t  status,
  output sccl_pkg::cmd_t     cmd
);
  import sccl_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_LOAD = 4'b0010,
    ST_DIV  = 4'b0100,
    ST_DONE = 4'b1000
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next  = state;
    cmd.start   = 1'b0;
    cmd.load    = 1'b0;
    cmd.step    = 1'b0;
    cmd.publish = 1'b0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load   = 1'b1;
        state_next = ST_DIV;
      end
      ST_DIV: begin
        cmd.step = 1'b1;
        if (status.last_step) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.publish = 1'b1;
          state_next  = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  `SCCL_ASSERT(a_accept_loads, (in_valid && in_ready) |=> (state == ST_LOAD), "accept must go to load")
  `SCCL_ASSERT(a_publish_free, cmd.publish |-> status.out_free, "publish into a full output register")
  `SCCL_ASSERT(a_div_exit, (state == ST_DIV && status.last_step) |=> (state == ST_DONE), "divider exit lost")

endmodule

### rtl/sccl_dp.sv
`include "supercap_charge_and_speed_limit_defines.svh"

module sccl_dp (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [sccl_pkg::CfgAddrW-1:0]      cfg_addr,
  input  logic [sccl_pkg::CfgDataW-1:0]      cfg_wdata,
  input  sccl_pkg::in_t                      in_data,
  input  sccl_pkg::cmd_t                     cmd,
  output sccl_pkg::status_t                  status,
  output sccl_pkg::out_t                     out_data,
  output logic                               out_valid,
  input  logic                               out_ready
);
  import sccl_pkg::*;

  logic [7:0]  pwr_ceil;
  logic [11:0] limit_voltage;
  logic [5:0]  buf_floor;
  logic        flag;

  logic [1:0]  mode_r;
  logic [14:0] ref_r;
  logic [13:0] wheel_r;
  logic [15:0] volt_r;
  logic [DivBits-1:0] dvd;
  logic [15:0] rem;
  logic [CntW-1:0] cnt;

  logic [5:0]  buf_sat;
  logic [1:0]  mode_c;
  logic        flag_next;
  logic [14:0] avail;
  logic [16:0] need;
  logic [14:0] ref_c;
  logic [13:0] wheel_c;
  logic [DivBits-1:0] ref_ext;
  logic [DivBits-1:0] ref_x100;
  logic [16:0] rem_sh;
  logic        ge;
  logic [16:0] rem_sub;
  logic [9:0]  cur_c;

  // per-item decisions taken at accept
  always_comb begin
    buf_sat = (in_data.buffer_energy > BUFFER_CAP_J) ? BUFFER_CAP_J[5:0]
                                                     : in_data.buffer_energy[5:0];
    if (in_data.protect_req) begin
      mode_c = MODE_OFF;
    end else if (in_data.boost_request) begin
      mode_c = ((in_data.cap_voltage >= {4'd0, limit_voltage}) && flag) ? MODE_BOOST
                                                                        : MODE_OFF;
    end else begin
      mode_c = (buf_sat <= buf_floor) ? MODE_OFF : MODE_CHARGE;
    end

    if (in_data.cap_voltage < VOLT_LOW_CV) begin
      flag_next = 1'b0;
    end else if (in_data.cap_voltage >= VOLT_HIGH_CV) begin
      flag_next = 1'b1;
    end else begin
      flag_next = flag & ~in_data.protect_req;
    end

    avail = 15'(pwr_ceil * 15'd100);
    need  = {1'b0, in_data.motor_power} + POWER_MARGIN_CW;
    if (mode_c != MODE_OFF && {2'b00, avail} > need) begin
      ref_c = 15'({2'b00, avail} - need);
    end else begin
      ref_c = '0;
    end

    if (in_data.boost_request && in_data.cap_voltage >= VOLT_LOW_CV && flag_next) begin
      wheel_c = BOOST_WHEEL;
    end else begin
      wheel_c = wheel_lookup(pwr_ceil);
    end
  end

  // ref * 100 as shifts
  assign ref_ext  = {{(DivBits-15){1'b0}}, ref_r};
  assign ref_x100 = (ref_ext << 6) + (ref_ext << 5) + (ref_ext << 2);

  // restoring division step
  assign rem_sh  = {rem, dvd[DivBits-1]};
  assign ge      = rem_sh >= {1'b0, volt_r};
  assign rem_sub = rem_sh - {1'b0, volt_r};

  // zero divisor gives an all-ones quotient, which clamps to full current
  always_comb begin
    if (ref_r == '0) begin
      cur_c = '0;
    end else if (dvd > {{(DivBits-10){1'b0}}, CURRENT_MAX_CA}) begin
      cur_c = CURRENT_MAX_CA;
    end else begin
      cur_c = dvd[9:0];
    end
  end

  assign status.last_step = (cnt == CntW'(DivBits-1));
  assign status.out_free  = ~out_valid | out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pwr_ceil      <= 8'd50;
      limit_voltage <= 12'd1350;
      buf_floor     <= 6'd40;
      flag          <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_addr)
          REG_PWR_CEIL:      pwr_ceil      <= cfg_wdata[7:0];
          REG_LIMIT_VOLTAGE: limit_voltage <= cfg_wdata;
          REG_BUF_FLOOR:     buf_floor     <= cfg_wdata[5:0];
          default: ;
        endcase
      end
      if (cmd.start) begin
        flag <= flag_next;
      end
      if (cmd.publish) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      mode_r  <= mode_c;
      ref_r   <= ref_c;
      wheel_r <= wheel_c;
      volt_r  <= in_data.cap_voltage;
    end
    if (cmd.load) begin
      dvd <= ref_x100;
      rem <= '0;
      cnt <= '0;
    end else if (cmd.step) begin
      dvd <= {dvd[DivBits-2:0], ge};
      rem <= ge ? rem_sub[15:0] : rem_sh[15:0];
      cnt <= cnt + 1'b1;
    end
    if (cmd.publish) begin
      out_data.cap_mode          <= mode_r;
      out_data.power_ref_cw      <= ref_r;
      out_data.charge_current    <= cur_c;
      out_data.wheel_speed_limit <= wheel_r;
      out_data.discharge_enable  <= flag;
    end
  end

  `SCCL_ASSERT_ALWAYS(a_rst_clears, rst |=> !out_valid, "output valid survives reset")
  `SCCL_ASSERT(a_publish_shows, cmd.publish |=> out_valid, "published item not shown")
  `SCCL_ASSERT(a_cur_max,
               out_valid |-> (out_data.charge_current <= CURRENT_MAX_CA),
               "current above clamp")
  `SCCL_ASSERT(a_off_zero,
               (out_valid && out_data.cap_mode == MODE_OFF) |->
               (out_data.power_ref_cw == '0 && out_data.charge_current == '0),
               "power in mode off")

endmodule

### rtl/supercap_charge_and_speed_limit.sv
// accept to output valid: load, one restoring divide step per dividend bit, then publish once
// the output register is free; the next item waits for the bit-serial divider (ref*100/voltage)
// a new item is taken while the previous result still sits in the output register
// reset (synchronous, active high): controller idle, output empty, discharge flag cleared,
// power ceiling 50 W, boost voltage limit 1350, buffer floor 40
module supercap_charge_and_speed_limit (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_we,
  input  logic [sccl_pkg::CfgAddrW-1:0]  cfg_addr,
  input  logic [sccl_pkg::CfgDataW-1:0]  cfg_wdata,
  // item input
  input  logic                           in_valid,
  output logic                           in_ready,
  input  sccl_pkg::in_t                  in_data,
  // item output
  output logic                           out_valid,
  input  logic                           out_ready,
  output sccl_pkg::out_t                 out_data
);
  import sccl_pkg::*;

  cmd_t    cmd;
  status_t status;

  // controller: idle -> load -> divide -> done, one item at a time
  sccl_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: config registers, hysteresis flag, mode and power decisions,
  // serial divider and output register
  sccl_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .status    (status),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_ready (out_ready)
  );

endmodule
